// ===== rtl/psim_pkg.sv =====
// Shared types, constants and codes for the per-slot input modifier.
package psim_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int MAX_SLOTS     = 16;

  localparam int LEVEL_W = 16;
  localparam int MODS_W  = 48;
  localparam int CFG_W   = 48;
  localparam int CFG_IDX_W = 2;

  localparam logic [LEVEL_W-1:0] FULL_SCALE = 16'hFFFF;
  localparam logic [LEVEL_W-1:0] ZERO_SCALE = 16'h0000;
  localparam logic [LEVEL_W-1:0] ROUND_HALF = 16'h7FFF;

  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLEW_STEP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_MODS   = 2'd2;

  typedef enum logic [2:0] {
    MOD_NONE   = 3'd0,
    MOD_DINV   = 3'd1,
    MOD_TOGGLE = 3'd2,
    MOD_SLEW   = 3'd3,
    MOD_AINV   = 3'd4,
    MOD_SMOOTH = 3'd5
  } mod_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] published;
    logic [LEVEL_W-1:0] smoothed;
    logic [LEVEL_W-1:0] slewed;
    logic               last_dig;
    logic               toggle;
    logic [2:0]         applied;
  } slot_state_t;

endpackage

// ===== rtl/psim_state.sv =====
// Per-slot state store with one read port and one write port.
module psim_state #(
  parameter int NUM_SLOTS = psim_pkg::NUM_SLOTS_DEF,
  parameter int SLOT_W    = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [SLOT_W-1:0]         rd_idx,
  output psim_pkg::slot_state_t     rd_state,
  input  logic                      wr_en,
  input  logic [SLOT_W-1:0]         wr_idx,
  input  psim_pkg::slot_state_t     wr_state
);
  import psim_pkg::*;

  slot_state_t state_r [NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        state_r[i] <= '0;
      end
    end else if (wr_en) begin
      state_r[wr_idx] <= wr_state;
    end
  end

  assign rd_state = state_r[rd_idx];

endmodule

// ===== rtl/psim_cond.sv =====
// Level conditioning for one reading: modifier reload, toggle, slew and smoothing.
module psim_cond (
  input  psim_pkg::slot_state_t  st,
  input  logic [2:0]             code,
  input  logic [15:0]            level,
  input  logic [15:0]            rate,
  input  logic [15:0]            step,
  output psim_pkg::slot_state_t  st_nxt
);
  import psim_pkg::*;

  logic        high;
  logic [15:0] dval;
  logic        chg;
  logic [15:0] sm_cur;
  logic [15:0] sl_cur;
  logic        tog_cur;
  logic        ld_cur;
  logic        tog_new;
  logic        up;
  logic [15:0] mag;
  logic [31:0] prod;
  logic [32:0] biased;
  logic [16:0] q1;
  logic [17:0] rem;
  logic [16:0] inc;
  logic [15:0] sm_new;
  logic [15:0] sl_diff;
  logic [15:0] sl_new;
  logic [15:0] result;

  always_comb begin
    high    = level[15];
    dval    = high ? FULL_SCALE : ZERO_SCALE;
    chg     = (st.applied != code);
    sm_cur  = chg ? st.published : st.smoothed;
    sl_cur  = chg ? st.published : st.slewed;
    tog_cur = chg ? 1'b0 : st.toggle;
    ld_cur  = chg ? 1'b0 : st.last_dig;
    tog_new = tog_cur ^ (high & ~ld_cur);

    // smoothing: divide by 65535 as q1 = x >> 16 with remainder q1 + low word
    up     = (level >= sm_cur);
    mag    = up ? (level - sm_cur) : (sm_cur - level);
    prod   = 32'(mag) * 32'(rate);
    biased = {1'b0, prod} + {17'd0, ROUND_HALF};
    q1     = biased[32:16];
    rem    = {2'b00, biased[15:0]} + {1'b0, q1};
    if (rem >= {1'b0, FULL_SCALE, 1'b0}) begin
      inc = q1 + 17'd2;
    end else if (rem >= {2'b00, FULL_SCALE}) begin
      inc = q1 + 17'd1;
    end else begin
      inc = q1;
    end
    sm_new = up ? (sm_cur + inc[15:0]) : (sm_cur - inc[15:0]);

    // slew toward the digital value, stop at it
    if (sl_cur < dval) begin
      sl_diff = dval - sl_cur;
      sl_new  = (sl_diff <= step) ? dval : (sl_cur + step);
    end else if (sl_cur > dval) begin
      sl_diff = sl_cur - dval;
      sl_new  = (sl_diff <= step) ? dval : (sl_cur - step);
    end else begin
      sl_diff = '0;
      sl_new  = sl_cur;
    end

    st_nxt.smoothed = sm_cur;
    st_nxt.slewed   = sl_cur;
    st_nxt.toggle   = tog_cur;
    st_nxt.last_dig = high;
    st_nxt.applied  = code;
    result          = level;
    case (mod_t'(code))
      MOD_DINV: begin
        result = FULL_SCALE - dval;
      end
      MOD_TOGGLE: begin
        st_nxt.toggle = tog_new;
        result        = tog_new ? FULL_SCALE : ZERO_SCALE;
      end
      MOD_SLEW: begin
        st_nxt.slewed = sl_new;
        result        = sl_new;
      end
      MOD_AINV: begin
        result = FULL_SCALE - level;
      end
      MOD_SMOOTH: begin
        st_nxt.smoothed = sm_new;
        result          = sm_new;
      end
      default: begin
        result = level;
      end
    endcase
    st_nxt.published = result;
  end

endmodule

// ===== rtl/per_slot_input_modifier.sv =====
// Per-slot input modifier: input register, conditioning and result register.
// An accepted input beat passes from the input register through conditioning into the result register.
// Throughput: one beat per cycle while out_tready does not stall the result register; slot state
// is read and written in the same cycle, so a reading for the same slot may follow directly.
// Readings whose slot is at or above NUM_SLOTS are dropped without a result.
// Reset (rst_n low, synchronous) clears both stages, all slot state and the registers.
module per_slot_input_modifier #(
  parameter int NUM_SLOTS = psim_pkg::NUM_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [31:0]                       in_tdata,  // slot_in[7:0], level_in[23:8], pin_in[31:24]
  input  logic [2:0]                        in_tuser,  // kind_in[2:0]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [31:0]                       out_tdata, // slot_out[3:0], level_out[19:4], pin_out[27:20], zero
  output logic [2:0]                        out_tuser, // kind_out[2:0]
  input  logic                              cfg_wr_en,
  input  logic [psim_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [psim_pkg::CFG_W-1:0]        cfg_wdata
);
  import psim_pkg::*;

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [7:0] SLOT_LIMIT = 8'(NUM_SLOTS);

  logic [15:0] cfg_rate_r;
  logic [15:0] cfg_step_r;
  logic [MODS_W-1:0] cfg_mods_r;

  logic        s1_valid_r;
  logic [7:0]  s1_slot_r;
  logic [15:0] s1_level_r;
  logic [7:0]  s1_pin_r;
  logic [2:0]  s1_kind_r;

  logic        out_valid_r;
  logic [3:0]  out_slot_r;
  logic [15:0] out_level_r;
  logic [7:0]  out_pin_r;
  logic [2:0]  out_kind_r;

  logic        out_free;
  logic        s1_in_range;
  logic        s1_adv;
  logic        s1_write;
  logic [SLOT_W-1:0] s1_idx;
  logic [MODS_W-1:0] mods_shift;
  logic [2:0]  s1_code;
  slot_state_t st_rd;
  slot_state_t st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_rate_r <= '0;
      cfg_step_r <= '0;
      cfg_mods_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SMOOTH_RATE: cfg_rate_r <= cfg_wdata[15:0];
        CFG_SLEW_STEP:   cfg_step_r <= cfg_wdata[15:0];
        CFG_SLOT_MODS:   cfg_mods_r <= cfg_wdata[MODS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_free    = !out_valid_r || out_tready;
  assign s1_in_range = (s1_slot_r < SLOT_LIMIT);
  assign s1_adv      = !s1_valid_r || !s1_in_range || out_free;
  assign s1_write    = s1_valid_r && s1_in_range && out_free;
  assign in_tready   = s1_adv;
  assign s1_idx      = s1_slot_r[SLOT_W-1:0];
  assign mods_shift  = cfg_mods_r >> ({2'b00, s1_slot_r[3:0]} * 6'd3);
  assign s1_code     = mods_shift[2:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_tvalid) begin
      s1_slot_r  <= in_tdata[7:0];
      s1_level_r <= in_tdata[23:8];
      s1_pin_r   <= in_tdata[31:24];
      s1_kind_r  <= in_tuser;
    end
  end

  psim_state #(
    .NUM_SLOTS (NUM_SLOTS),
    .SLOT_W    (SLOT_W)
  ) u_state (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (s1_idx),
    .rd_state (st_rd),
    .wr_en    (s1_write),
    .wr_idx   (s1_idx),
    .wr_state (st_nxt)
  );

  psim_cond u_cond (
    .st     (st_rd),
    .code   (s1_code),
    .level  (s1_level_r),
    .rate   (cfg_rate_r),
    .step   (cfg_step_r),
    .st_nxt (st_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_write) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_write) begin
      out_slot_r  <= s1_slot_r[3:0];
      out_level_r <= st_nxt.published;
      out_pin_r   <= s1_pin_r;
      out_kind_r  <= s1_kind_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_pin_r, out_level_r, out_slot_r};
  assign out_tuser  = out_kind_r;

`ifndef SYNTHESIS
  a_write_shows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_write |=> out_valid_r)
    else $error("result register not loaded after slot update");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && s1_in_range && out_valid_r && !out_tready))
    else $error("input stalled without a blocked result");

  a_toggle_level: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_write && (s1_code == MOD_TOGGLE)) |=>
      ((out_level_r == FULL_SCALE) || (out_level_r == ZERO_SCALE)))
    else $error("toggle result is not a digital level");
`endif

endmodule

// ===== bench/tb_per_slot_input_modifier.sv =====
// Testbench for the per-slot input modifier: stream stimulus, per-slot predictor and scoreboard.
`timescale 1ns / 1ps

module tb_per_slot_input_modifier;
  import psim_pkg::*;

  localparam int SLOTS = NUM_SLOTS_DEF;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [LEVEL_W-1:0] DIGITAL_HIGH = 16'h8000;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN_CYCLES = 6;
  localparam int PHASES = 10;
  localparam int BEATS_PER_PHASE = 68;

  typedef struct {
    logic [3:0]         slot;
    logic [LEVEL_W-1:0] level;
    logic [7:0]         pin;
    logic [2:0]         kind;
  } reading_t;

  class slot_conditioner;
    logic [LEVEL_W-1:0] rate;
    logic [LEVEL_W-1:0] step;
    logic [MODS_W-1:0]  mods;
    logic [LEVEL_W-1:0] published [MAX_SLOTS];
    logic [LEVEL_W-1:0] smoothed [MAX_SLOTS];
    logic [LEVEL_W-1:0] slewed [MAX_SLOTS];
    logic               last_dig [MAX_SLOTS];
    logic               toggled [MAX_SLOTS];
    logic [2:0]         applied [MAX_SLOTS];
    reading_t           expected_readings [$];
    int                 errors;

    function new();
      rate = '0;
      step = '0;
      mods = '0;
      errors = 0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        published[i] = '0;
        smoothed[i] = '0;
        slewed[i] = '0;
        last_dig[i] = 1'b0;
        toggled[i] = 1'b0;
        applied[i] = MOD_NONE;
      end
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        CFG_SMOOTH_RATE: rate = value[LEVEL_W-1:0];
        CFG_SLEW_STEP:   step = value[LEVEL_W-1:0];
        CFG_SLOT_MODS:   mods = value[MODS_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_reading(logic [31:0] d, logic [2:0] u);
      int                 s;
      logic [LEVEL_W-1:0] lvl;
      logic [LEVEL_W-1:0] dval;
      logic [LEVEL_W-1:0] res;
      logic [LEVEL_W-1:0] mag;
      logic [LEVEL_W-1:0] inc;
      logic [32:0]        acc;
      logic [2:0]         code;
      logic               high;
      reading_t           r;
      s = int'(d[7:0]);
      lvl = d[23:8];
      if (s >= SLOTS) return;
      code = mods[3*s +: 3];
      high = lvl >= DIGITAL_HIGH;
      dval = high ? FULL_SCALE : ZERO_SCALE;
      if (applied[s] != code) begin
        smoothed[s] = published[s];
        slewed[s] = published[s];
        last_dig[s] = 1'b0;
        toggled[s] = 1'b0;
        applied[s] = code;
      end
      res = lvl;
      case (code)
        MOD_DINV: res = FULL_SCALE - dval;
        MOD_TOGGLE: begin
          if (high && !last_dig[s]) toggled[s] = !toggled[s];
          res = toggled[s] ? FULL_SCALE : ZERO_SCALE;
        end
        MOD_SLEW: begin
          if (slewed[s] < dval)
            slewed[s] = (dval - slewed[s] <= step) ? dval : slewed[s] + step;
          else if (slewed[s] > dval)
            slewed[s] = (slewed[s] - dval <= step) ? dval : slewed[s] - step;
          res = slewed[s];
        end
        MOD_AINV: res = FULL_SCALE - lvl;
        MOD_SMOOTH: begin
          mag = (lvl >= smoothed[s]) ? lvl - smoothed[s] : smoothed[s] - lvl;
          acc = {17'd0, mag} * {17'd0, rate};
          acc = acc + {17'd0, ROUND_HALF};
          acc = acc / 33'd65535;
          inc = acc[LEVEL_W-1:0];
          smoothed[s] = (lvl >= smoothed[s]) ? smoothed[s] + inc : smoothed[s] - inc;
          res = smoothed[s];
        end
        default: ;
      endcase
      last_dig[s] = high;
      published[s] = res;
      r.slot = s[3:0];
      r.level = res;
      r.pin = d[31:24];
      r.kind = u;
      expected_readings.push_back(r);
    endfunction

    function void compare(string name, logic [LEVEL_W-1:0] want, logic [LEVEL_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [31:0] d, logic [2:0] u);
      reading_t r;
      if (expected_readings.size() == 0) begin
        $error("result beat with nothing expected: tdata %h tuser %h", d, u);
        errors++;
        return;
      end
      r = expected_readings.pop_front();
      compare("slot_out", {12'b0, r.slot}, {12'b0, d[3:0]});
      compare("level_out", r.level, d[19:4]);
      compare("pin_out", {8'b0, r.pin}, {8'b0, d[27:20]});
      compare("tdata_pad", '0, {12'b0, d[31:28]});
      compare("kind_out", {13'b0, r.kind}, {13'b0, u});
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [31:0]          in_tdata;
  logic [2:0]           in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [31:0]          out_tdata;
  logic [2:0]           out_tuser;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  bit in_idle_on = 1'b1;
  bit out_idle_on = 1'b1;
  bit hold_long = 1'b0;

  slot_conditioner conditioner = new();

  per_slot_input_modifier dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && cfg_wr_en) conditioner.set_register(cfg_index, cfg_wdata);
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) conditioner.note_reading(in_tdata, in_tuser);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) conditioner.check_result(out_tdata, out_tuser);
  end

  initial begin
    int n;
    forever begin
      if (hold_long) begin
        hold_long = 1'b0;
        out_tready <= 1'b0;
        n = LONG_HOLD;
      end else if (out_idle_on && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 14);
      end else begin
        out_tready <= 1'b1;
        n = $urandom_range(1, 20);
      end
      repeat (n) @(posedge clk);
    end
  end

  task automatic send_reading(input logic [7:0] slot, input logic [LEVEL_W-1:0] level,
                              input logic [7:0] pin, input logic [2:0] kind);
    if (in_idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {pin, level, slot};
    in_tuser <= kind;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain_block();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (conditioner.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic configure(input logic [LEVEL_W-1:0] rate, input logic [LEVEL_W-1:0] step,
                           input logic [MODS_W-1:0] mods);
    write_register(CFG_SMOOTH_RATE, {32'b0, rate});
    write_register(CFG_SLEW_STEP, {32'b0, step});
    write_register(CFG_SLOT_MODS, mods);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_random_tag(input logic [7:0] slot, input logic [LEVEL_W-1:0] level);
    send_reading(slot, level, 8'($urandom), 3'($urandom_range(0, 7)));
  endtask

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [MODS_W-1:0]  pattern;
    logic [MODS_W-1:0]  mods_word;
    logic [7:0]         slot;
    logic [LEVEL_W-1:0] level;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    for (int s = 0; s < MAX_SLOTS; s++) pattern[3*s +: 3] = s[2:0];
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_reading(8'd0, FULL_SCALE, 8'hFF, 3'd7);
    send_reading(8'd15, ZERO_SCALE, 8'h00, 3'd0);
    send_reading(8'd255, 16'h5A5A, 8'hA5, 3'd5);
    drain_block();

    write_register(CFG_UNUSED, CFG_W'({$urandom, $urandom}));
    configure(16'h4000, 16'h3000, pattern);
    send_random_tag(8'd1, 16'h7FFF);
    send_random_tag(8'd1, DIGITAL_HIGH);
    send_random_tag(8'd2, DIGITAL_HIGH);
    send_random_tag(8'd2, FULL_SCALE);
    send_random_tag(8'd2, ZERO_SCALE);
    send_random_tag(8'd2, DIGITAL_HIGH);
    send_random_tag(8'd3, FULL_SCALE);
    send_random_tag(8'd3, FULL_SCALE);
    send_random_tag(8'd3, ZERO_SCALE);
    send_random_tag(8'd4, ZERO_SCALE);
    send_random_tag(8'd4, FULL_SCALE);
    send_random_tag(8'd5, FULL_SCALE);
    send_random_tag(8'd5, FULL_SCALE);
    send_random_tag(8'd5, ZERO_SCALE);
    send_random_tag(8'd6, 16'h1234);
    send_random_tag(8'd7, 16'hABCD);
    send_random_tag(8'd8, 16'h5555);
    send_random_tag(8'd16, 16'h8001);
    send_random_tag(8'd128, 16'h0001);
    drain_block();

    for (int phase = 0; phase < PHASES; phase++) begin
      mods_word = MODS_W'({$urandom, $urandom});
      case (phase)
        0: configure(ZERO_SCALE, ZERO_SCALE, mods_word);
        1: configure(FULL_SCALE, FULL_SCALE, mods_word);
        2: configure(16'($urandom), 16'($urandom_range(1, 4096)), {16{MOD_SMOOTH}});
        3: configure(16'($urandom), 16'($urandom_range(256, 8192)), {16{MOD_SLEW}});
        4: configure(16'($urandom), 16'($urandom), {16{MOD_TOGGLE}});
        default: configure(16'($urandom), 16'($urandom), mods_word);
      endcase
      in_idle_on = (phase != PHASES - 1);
      out_idle_on = (phase != PHASES - 1);
      if (phase == 5) hold_long = 1'b1;
      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        if ($urandom_range(0, 9) == 0) slot = 8'($urandom_range(SLOTS, 255));
        else slot = 8'($urandom_range(0, (phase % 2) ? 3 : SLOTS - 1));
        case ($urandom_range(0, 5))
          0: level = ZERO_SCALE;
          1: level = FULL_SCALE;
          2: level = DIGITAL_HIGH - 16'd1;
          3: level = DIGITAL_HIGH;
          default: level = 16'($urandom);
        endcase
        send_random_tag(slot, level);
      end
      drain_block();
    end

    if (conditioner.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/psim_pkg.sv
rtl/psim_state.sv
rtl/psim_cond.sv
rtl/per_slot_input_modifier.sv
bench/tb_per_slot_input_modifier.sv
